>>> sv/acbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acbs_pkg
// Types, register indexes and AES helper functions shared by the counter-mode
// byte stream cipher core.
// ----------------------------------------------------------------------------
package acbs_pkg;

	// A 16-byte AES block; element 0 is the first (most significant) byte.
	typedef logic [0:15][7:0] aes_block_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_KEY_HIGH  = 3'd0,
		REG_KEY_LOW   = 3'd1,
		REG_BASE_HIGH = 3'd2,
		REG_BASE_LOW  = 3'd3,
		REG_CTR_BYTES = 3'd4
	} reg_idx_t;

	localparam logic [4:0] CTR_BYTES_RESET = 5'd8;
	localparam logic [4:0] CTR_BYTES_MAX   = 5'd16;
	localparam logic [3:0] AES_ROUNDS      = 4'd10;
	localparam logic [1:0] KS_SLOTS        = 2'd2;

	// Input opcodes.
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_SEEK = 1'b1;

	// Configuration as seen by the AES engine.
	typedef struct packed {
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic [63:0] base_high;
		logic [63:0] base_low;
		logic [4:0]  ctr_bytes;
	} cfg_t;

	// One classified request waiting between front and back.
	typedef struct packed {
		logic       need_ks;
		logic       is_data;
		logic [3:0] idx;
		logic [7:0] data;
		logic       eob;
	} q_entry_t;

	// Keystream job from the front to the AES engine.
	typedef struct packed {
		logic        valid;
		logic [63:0] pos;
	} job_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] sbox(input logic [7:0] a);
		return SBOX[a];
	endfunction

	// Multiply by x in GF(2^8).
	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

endpackage
`default_nettype wire

>>> sv/acbs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acbs_queue
// Short first-in first-out queue of classified requests between the front
// and the back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module acbs_queue #(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire acbs_pkg::q_entry_t push_entry,
	input  wire logic               pop,
	output acbs_pkg::q_entry_t      head,
	output logic                    empty,
	output logic                    full
);
	import acbs_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	q_entry_t          mem_q [DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [CW-1:0]     cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(DEPTH));
	assign head  = mem_q[rd_q];

	// Storage: written at the tail only.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/acbs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acbs_front
// Accepts requests, keeps the stream position and classifies each request:
// whether it needs a fresh keystream block and whether it yields a byte.
// ----------------------------------------------------------------------------
module acbs_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               opcode,
	input  wire logic [7:0]         data_byte,
	input  wire logic [63:0]        new_position,
	input  wire logic               end_of_buffer,
	output logic                    q_push,
	output acbs_pkg::q_entry_t      q_entry,
	input  wire logic               q_full,
	output acbs_pkg::job_t          job,
	input  wire logic               job_ready
);
	import acbs_pkg::*;

	logic [63:0] pos_q;
	logic        is_data;
	logic        moves;
	logic        need_ks;
	logic        need_entry;
	logic        accept;

	// Classification of the offered request.
	always_comb begin
		is_data    = (opcode == OP_DATA);
		moves      = !is_data && (new_position != pos_q);
		need_ks    = is_data ? (pos_q[3:0] == 4'd0) : (moves && (new_position[3:0] != 4'd0));
		need_entry = is_data || need_ks;
	end

	assign in_stall = (need_entry && q_full) || (need_ks && !job_ready);
	assign accept   = in_valid && !in_stall;

	// Request into the queue and keystream job to the engine.
	always_comb begin
		q_push          = accept && need_entry;
		q_entry.need_ks = need_ks;
		q_entry.is_data = is_data;
		q_entry.idx     = pos_q[3:0];
		q_entry.data    = data_byte;
		q_entry.eob     = end_of_buffer;
		job.valid       = accept && need_ks;
		job.pos         = is_data ? pos_q : new_position;
	end

	// Stream position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (is_data) begin
				pos_q <= pos_q + 64'd1;
			end else if (moves) begin
				pos_q <= new_position;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/acbs_aes_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acbs_aes_engine
// Builds the counter block for a position and encrypts it with AES-128, one
// round per cycle with the key schedule run alongside. Finished keystream
// blocks wait in a two-entry queue for the back.
// ----------------------------------------------------------------------------
module acbs_aes_engine (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire acbs_pkg::cfg_t     cfg,
	input  wire acbs_pkg::job_t     job,
	output logic                    job_ready,
	output logic                    ks_avail,
	output acbs_pkg::aes_block_t    ks_head,
	input  wire logic               ks_pop
);
	import acbs_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_ROUND} state_t;

	state_t      state_q;
	logic [63:0] pos_q;
	aes_block_t  st_q;
	aes_block_t  rk_q;
	logic [7:0]  rcon_q;
	logic [3:0]  rnd_q;

	aes_block_t  ks_mem_q [2];
	logic        ks_wr_q;
	logic        ks_rd_q;
	logic [1:0]  ks_cnt_q;

	logic [59:0] off;
	logic [64:0] lo_sum;
	logic [63:0] hi_sum;
	logic [63:0] m_lo;
	logic [63:0] m_hi;
	aes_block_t  ctr_blk;
	aes_block_t  key_blk;
	aes_block_t  sb;
	aes_block_t  mc;
	aes_block_t  nk;
	aes_block_t  next_st;
	logic [7:0]  tmp [4];
	logic        last;
	logic        ks_push;

	assign job_ready = (state_q == ST_IDLE) && (ks_cnt_q < KS_SLOTS);
	assign ks_avail  = (ks_cnt_q != 2'd0);
	assign ks_head   = ks_mem_q[ks_rd_q];
	assign last      = (rnd_q == AES_ROUNDS);
	assign ks_push   = (state_q == ST_ROUND) && last;
	assign key_blk   = aes_block_t'({cfg.key_high, cfg.key_low});

	// Counter block: low counter bytes of the base plus position / 16,
	// wrapping within those bytes.
	always_comb begin
		off    = pos_q[63:4];
		lo_sum = {1'b0, cfg.base_low} + {5'd0, off};
		hi_sum = cfg.base_high + {63'd0, lo_sum[64]};
		for (int k = 0; k < 8; k++) begin
			m_lo[8*k +: 8] = (cfg.ctr_bytes > 5'(k))     ? 8'hff : 8'h00;
			m_hi[8*k +: 8] = (cfg.ctr_bytes > 5'(k + 8)) ? 8'hff : 8'h00;
		end
		ctr_blk = aes_block_t'({(cfg.base_high & ~m_hi) | (hi_sum & m_hi),
			(cfg.base_low & ~m_lo) | (lo_sum[63:0] & m_lo)});
	end

	// One AES round: SubBytes and ShiftRows, then MixColumns but in the last round.
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				sb[j + 4*c] = sbox(st_q[j + 4*((c + j) & 3)]);
			end
		end
		for (int c = 0; c < 4; c++) begin
			logic [7:0] e;
			e = sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3];
			mc[4*c]   = sb[4*c]   ^ e ^ xt(sb[4*c]   ^ sb[4*c+1]);
			mc[4*c+1] = sb[4*c+1] ^ e ^ xt(sb[4*c+1] ^ sb[4*c+2]);
			mc[4*c+2] = sb[4*c+2] ^ e ^ xt(sb[4*c+2] ^ sb[4*c+3]);
			mc[4*c+3] = sb[4*c+3] ^ e ^ xt(sb[4*c+3] ^ sb[4*c]);
		end
	end

	// Next round key from the current one, and the next round state with that key added.
	always_comb begin
		tmp[0] = sbox(rk_q[13]) ^ rcon_q;
		tmp[1] = sbox(rk_q[14]);
		tmp[2] = sbox(rk_q[15]);
		tmp[3] = sbox(rk_q[12]);
		for (int j = 0; j < 4; j++) begin
			nk[j] = rk_q[j] ^ tmp[j];
		end
		for (int i = 4; i < 16; i++) begin
			nk[i] = rk_q[i] ^ nk[i-4];
		end
		next_st = (last ? sb : mc) ^ nk;
	end

	// Sequencer and round state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			rcon_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job.valid) begin
						pos_q   <= job.pos;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					st_q    <= ctr_blk ^ key_blk;
					rk_q    <= key_blk;
					rcon_q  <= 8'h01;
					rnd_q   <= 4'd1;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					st_q   <= next_st;
					rk_q   <= nk;
					rcon_q <= xt(rcon_q);
					rnd_q  <= rnd_q + 4'd1;
					if (last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Finished keystream storage.
	always_ff @(posedge clk) begin
		if (ks_push) begin
			ks_mem_q[ks_wr_q] <= next_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_wr_q  <= 1'b0;
			ks_rd_q  <= 1'b0;
			ks_cnt_q <= '0;
		end else begin
			if (ks_push) begin
				ks_wr_q <= !ks_wr_q;
			end
			if (ks_pop) begin
				ks_rd_q <= !ks_rd_q;
			end
			if (ks_push && !ks_pop) begin
				ks_cnt_q <= ks_cnt_q + 2'd1;
			end else if (ks_pop && !ks_push) begin
				ks_cnt_q <= ks_cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/acbs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acbs_back
// Takes classified requests from the queue, switches to a fresh keystream
// block where one is due, and XORs data bytes into the output register.
// ----------------------------------------------------------------------------
module acbs_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire acbs_pkg::q_entry_t    head,
	input  wire logic                  q_empty,
	output logic                       q_pop,
	input  wire logic                  ks_avail,
	input  wire acbs_pkg::aes_block_t  ks_head,
	output logic                       ks_pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [7:0]                 out_byte,
	output logic                       buffer_end
);
	import acbs_pkg::*;

	aes_block_t ks_q;
	aes_block_t blk;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       buffer_end_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = !q_empty && (!head.need_ks || ks_avail) && out_free;
	assign ks_pop   = q_pop && head.need_ks;
	assign blk      = head.need_ks ? ks_head : ks_q;

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign buffer_end = buffer_end_q;

	// Current keystream block.
	always_ff @(posedge clk) begin
		if (ks_pop) begin
			ks_q <= ks_head;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop && head.is_data) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && head.is_data) begin
			out_byte_q   <= head.data ^ blk[head.idx];
			buffer_end_q <= head.eob;
		end
	end

endmodule
`default_nettype wire

>>> sv/aes_ctr_byte_stream_cipher_core.sv
// Path: a byte inside a keystream block passes through the request queue and
// then the output register; a byte on a 16-byte boundary or after an unaligned
// seek also waits for its keystream block from the AES engine.
// Throughput: one byte per cycle sustained while in_stall and out_stall stay low;
// the AES engine, one round per cycle, runs ahead through the queue.
// Reset: asynchronous, active low; position zero, counter_bytes 8, queues empty.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_ctr_byte_stream_cipher_core
// AES-128 counter-mode byte stream cipher: front classifier, request queue,
// AES keystream engine and XOR back end.
// ----------------------------------------------------------------------------
module aes_ctr_byte_stream_cipher_core #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [7:0]  data_byte,
	input  wire logic [63:0] new_position,
	input  wire logic        end_of_buffer,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             buffer_end
);
	import acbs_pkg::*;

	cfg_t       cfg_q;
	q_entry_t   q_in;
	q_entry_t   q_head;
	logic       q_push;
	logic       q_pop;
	logic       q_empty;
	logic       q_full;
	job_t       job;
	logic       job_ready;
	logic       ks_avail;
	logic       ks_pop;
	aes_block_t ks_head;

	// Configuration registers; counter_bytes is clamped on write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_high  <= '0;
			cfg_q.key_low   <= '0;
			cfg_q.base_high <= '0;
			cfg_q.base_low  <= '0;
			cfg_q.ctr_bytes <= CTR_BYTES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_HIGH:  cfg_q.key_high  <= cfg_wdata;
				REG_KEY_LOW:   cfg_q.key_low   <= cfg_wdata;
				REG_BASE_HIGH: cfg_q.base_high <= cfg_wdata;
				REG_BASE_LOW:  cfg_q.base_low  <= cfg_wdata;
				REG_CTR_BYTES: cfg_q.ctr_bytes <= (cfg_wdata[4:0] > CTR_BYTES_MAX) ?
					CTR_BYTES_MAX : cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	acbs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.data_byte     (data_byte),
		.new_position  (new_position),
		.end_of_buffer (end_of_buffer),
		.q_push        (q_push),
		.q_entry       (q_in),
		.q_full        (q_full),
		.job           (job),
		.job_ready     (job_ready)
	);

	acbs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty),
		.full       (q_full)
	);

	acbs_aes_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job       (job),
		.job_ready (job_ready),
		.ks_avail  (ks_avail),
		.ks_head   (ks_head),
		.ks_pop    (ks_pop)
	);

	acbs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.ks_avail   (ks_avail),
		.ks_head    (ks_head),
		.ks_pop     (ks_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.buffer_end (buffer_end)
	);

endmodule
`default_nettype wire

>>> sv/acbs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acbs_checker
// Port-level checks for the cipher core: output handshake and the balance
// between data requests taken and bytes delivered.
// ----------------------------------------------------------------------------
module acbs_checker #(
	parameter int QUEUE_DEPTH = 16
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       opcode,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic       buffer_end
);
	import acbs_pkg::*;

	logic [7:0] pending_q;
	logic       data_in;
	logic       data_out;

	assign data_in  = in_valid && !in_stall && (opcode == OP_DATA);
	assign data_out = out_valid && !out_stall;

	// Data bytes taken but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (data_in && !data_out) begin
			pending_q <= pending_q + 8'd1;
		end else if (data_out && !data_in) begin
			pending_q <= pending_q - 8'd1;
		end
	end

	// A stalled result stays offered with the same payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(buffer_end))
		else $error("stalled output changed");

	// No byte is delivered without a data request behind it.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 8'd0)
		else $error("output without a pending data request");

	// Bytes in flight never exceed the queue plus the output register.
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 8'(QUEUE_DEPTH + 1))
		else $error("more data requests in flight than storage allows");

endmodule

bind aes_ctr_byte_stream_cipher_core acbs_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_acbs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.opcode     (opcode),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_byte   (out_byte),
	.buffer_end (buffer_end)
);
`default_nettype wire
